FILE: hw/rtl/wp_pkg.sv
// Shared types and constants for the window pooling block.
`default_nettype none

package wp_pkg;

   localparam int WP_MAX_WIDTH    = 1024;
   localparam int WP_MAX_WINDOW   = 8;
   localparam int WP_HEIGHT_LIMIT = 1024;
   localparam int WP_ROW_W        = 10;
   localparam int WP_SAMPLE_W     = 16;
   localparam int WP_CFG_W        = 11;
   localparam int WP_CSR_ADDR_W   = 3;

   typedef enum logic [WP_CSR_ADDR_W-1:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_WINDOW_ROWS  = 3'd2,
      REG_WINDOW_COLS  = 3'd3,
      REG_POOL_MODE    = 3'd4
   } wp_reg_type;

   typedef enum logic {
      MODE_MAX = 1'b0,
      MODE_AVG = 1'b1
   } wp_mode_type;

   // Divider status back to the controller.
   typedef struct packed {
      logic busy;
      logic done;
   } wp_div_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/wp_row_store.sv
// Per-column partial store: one write port, one read port, registered read data.
`default_nettype none

module wp_row_store #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 23
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/wp_divider.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module wp_divider #(
   parameter int ACC_W  = 23,
   parameter int AREA_W = 7
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [ACC_W-1:0]     dividend,
   input  wire logic        [AREA_W-1:0]    divisor,
   output wp_pkg::wp_div_status_type        status,
   output logic signed      [ACC_W-1:0]     quotient
);

   import wp_pkg::*;

   localparam int STEP_W = $clog2(ACC_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [ACC_W-1:0]  work_ff;
   logic [AREA_W-1:0] rem_ff;
   logic [AREA_W-1:0] div_ff;
   logic              neg_ff;

   logic [ACC_W-1:0]  magnitude;
   logic [AREA_W:0]   rem_shift;
   logic              qbit;
   logic [AREA_W-1:0] rem_in;

   assign magnitude = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
   assign rem_shift = {rem_ff, work_ff[ACC_W-1]};
   assign qbit      = (rem_shift >= {1'b0, div_ff});
   assign rem_in    = qbit ? AREA_W'(rem_shift - {1'b0, div_ff}) : AREA_W'(rem_shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         // pulse on the last quotient bit
         done_ff <= busy_ff && (step_ff == STEP_W'(1));
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(ACC_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         work_ff <= magnitude;
         rem_ff  <= '0;
         div_ff  <= divisor;
         neg_ff  <= dividend[ACC_W-1];
      end else if (busy_ff) begin
         work_ff <= {work_ff[ACC_W-2:0], qbit};
         rem_ff  <= rem_in;
      end
   end

   assign quotient    = neg_ff ? -$signed(work_ff) : $signed(work_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/window_pooling_2d.sv
// Top level of the 2-D window pooling block: position tracking, row store update, output register.
//
//   channel | dir | payload                                   | transfer
//   req     | in  | tdata[15:0] sample (Q8.8)                  | tvalid & tready
//   rsp     | out | tdata[15:0] pooled_value, tlast row_end,   | tvalid & tready
//           |     | tuser frame_end                           |
//   csr     | in  | csr_addr register index, csr_wdata value   | csr_we
//
// One request at a time. A sample with no result passes through accept and the row store
// read-modify-write. A max result then goes to the emit step. An average result first
// waits in the divide step for the serial divider, one quotient bit a cycle.
// A full output register holds the block in its emit step until rsp_tready.
// Reset clears counters, config, state and output valid; the row store is not cleared,
// a window's first sample overwrites its entry. A write to a listed csr restarts the frame.
`default_nettype none

module window_pooling_2d #(
   parameter int MAX_WIDTH  = wp_pkg::WP_MAX_WIDTH,
   parameter int MAX_WINDOW = wp_pkg::WP_MAX_WINDOW
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [wp_pkg::WP_SAMPLE_W-1:0]   req_tdata,   // [15:0] sample
   // result channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [wp_pkg::WP_SAMPLE_W-1:0]   rsp_tdata,   // [15:0] pooled_value
   output logic                                  rsp_tlast,   // row_end
   output logic                                  rsp_tuser,   // [0] frame_end
   // configuration port
   input  wire logic                             csr_we,
   input  wire logic [wp_pkg::WP_CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [wp_pkg::WP_CFG_W-1:0]      csr_wdata
);

   import wp_pkg::*;

   localparam int POS_W  = $clog2(MAX_WIDTH);
   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int WIN_W  = $clog2(MAX_WINDOW);
   localparam int WSZ_W  = $clog2(MAX_WINDOW + 1);
   localparam int AREA_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int ACC_W  = WP_SAMPLE_W + 1 + $clog2(MAX_WINDOW * MAX_WINDOW);
   localparam int HGT_W  = WP_ROW_W + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_DIV,
      S_EMIT
   } state_type;

   // ---------------- configuration registers ----------------
   logic [WP_CFG_W-1:0] image_width_ff;
   logic [WP_CFG_W-1:0] image_height_ff;
   logic [3:0]          window_rows_ff;
   logic [3:0]          window_cols_ff;
   logic                pool_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WP_CFG_W'(1024);
         image_height_ff <= WP_CFG_W'(1024);
         window_rows_ff  <= 4'd2;
         window_cols_ff  <= 4'd2;
         pool_mode_ff    <= MODE_MAX;
      end else if (csr_we) begin
         unique case (wp_reg_type'(csr_addr))
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            REG_WINDOW_ROWS:  window_rows_ff  <= csr_wdata[3:0];
            REG_WINDOW_COLS:  window_cols_ff  <= csr_wdata[3:0];
            REG_POOL_MODE:    pool_mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Any write to a listed register restarts the frame.
   logic csr_restart;
   assign csr_restart = csr_we && (32'(csr_addr) <= 32'(REG_POOL_MODE));

   // Effective sizes: zero reads as one, large values saturate.
   logic [CNT_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;
   logic [WSZ_W-1:0] wr_eff;
   logic [WSZ_W-1:0] wc_eff;

   always_comb begin
      if (image_width_ff == '0)                 w_eff = CNT_W'(1);
      else if (32'(image_width_ff) > MAX_WIDTH) w_eff = CNT_W'(MAX_WIDTH);
      else                                      w_eff = CNT_W'(image_width_ff);

      if (image_height_ff == '0)                       h_eff = HGT_W'(1);
      else if (32'(image_height_ff) > WP_HEIGHT_LIMIT) h_eff = HGT_W'(WP_HEIGHT_LIMIT);
      else                                             h_eff = HGT_W'(image_height_ff);

      if (window_rows_ff == '0)                  wr_eff = WSZ_W'(1);
      else if (32'(window_rows_ff) > MAX_WINDOW) wr_eff = WSZ_W'(MAX_WINDOW);
      else                                       wr_eff = WSZ_W'(window_rows_ff);

      if (window_cols_ff == '0)                  wc_eff = WSZ_W'(1);
      else if (32'(window_cols_ff) > MAX_WINDOW) wc_eff = WSZ_W'(MAX_WINDOW);
      else                                       wc_eff = WSZ_W'(window_cols_ff);
   end

   logic [AREA_W-1:0] area;
   assign area = AREA_W'(32'(wr_eff) * 32'(wc_eff));

   // ---------------- position counters ----------------
   logic [POS_W-1:0]    col_pos_ff,    col_pos_in;
   logic [WP_ROW_W-1:0] row_pos_ff,    row_pos_in;
   logic [WIN_W-1:0]    col_in_win_ff, col_in_win_in;
   logic [WIN_W-1:0]    row_in_win_ff, row_in_win_in;
   logic [POS_W-1:0]    slot_ff,       slot_in;   // column_position / wc, kept as a count

   state_type state_ff;
   logic      accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   logic first, last_col, last_row, col_wrap, row_wrap;
   logic win_col_end, win_row_end, emit, partial;

   always_comb begin
      first       = (row_in_win_ff == '0) && (col_in_win_ff == '0);
      last_col    = (32'(col_pos_ff) + 1 >= 32'(w_eff));
      last_row    = (32'(row_pos_ff) + 1 >= 32'(h_eff));
      col_wrap    = (32'(col_in_win_ff) + 1 >= 32'(wc_eff));
      row_wrap    = (32'(row_in_win_ff) + 1 >= 32'(wr_eff));
      win_col_end = col_wrap || last_col;
      win_row_end = row_wrap || last_row;
      emit        = win_col_end && win_row_end;
      partial     = !col_wrap || !row_wrap;
   end

   always_comb begin
      col_pos_in    = col_pos_ff;
      row_pos_in    = row_pos_ff;
      col_in_win_in = col_in_win_ff;
      row_in_win_in = row_in_win_ff;
      slot_in       = slot_ff;
      if (csr_restart) begin
         col_pos_in    = '0;
         row_pos_in    = '0;
         col_in_win_in = '0;
         row_in_win_in = '0;
         slot_in       = '0;
      end else if (accept) begin
         if (last_col) begin
            col_pos_in    = '0;
            col_in_win_in = '0;
            slot_in       = '0;
            if (last_row) begin
               row_pos_in    = '0;
               row_in_win_in = '0;
            end else begin
               row_pos_in    = row_pos_ff + WP_ROW_W'(1);
               row_in_win_in = row_wrap ? '0 : row_in_win_ff + WIN_W'(1);
            end
         end else begin
            col_pos_in    = col_pos_ff + POS_W'(1);
            col_in_win_in = col_wrap ? '0 : col_in_win_ff + WIN_W'(1);
            slot_in       = col_wrap ? slot_ff + POS_W'(1) : slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff    <= '0;
         row_pos_ff    <= '0;
         col_in_win_ff <= '0;
         row_in_win_ff <= '0;
         slot_ff       <= '0;
      end else begin
         col_pos_ff    <= col_pos_in;
         row_pos_ff    <= row_pos_in;
         col_in_win_ff <= col_in_win_in;
         row_in_win_ff <= row_in_win_in;
         slot_ff       <= slot_in;
      end
   end

   // ---------------- captured request ----------------
   logic [WP_SAMPLE_W-1:0] item_sample_ff;
   logic [POS_W-1:0]       item_slot_ff;
   logic                   item_first_ff;
   logic                   item_emit_ff;
   logic                   item_partial_ff;
   logic                   item_row_end_ff;
   logic                   item_frame_end_ff;
   logic                   item_mode_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         item_sample_ff    <= req_tdata;
         item_slot_ff      <= slot_ff;
         item_first_ff     <= first;
         item_emit_ff      <= emit;
         item_partial_ff   <= partial;
         item_row_end_ff   <= last_col;
         item_frame_end_ff <= last_col && last_row;
         item_mode_ff      <= pool_mode_ff;
      end
   end

   // ---------------- row store read-modify-write ----------------
   // The read is issued at the accept edge from the live slot; data lands for S_CALC.
   logic [ACC_W-1:0]        rd_data;
   logic signed [ACC_W-1:0] partial_val;
   logic signed [ACC_W-1:0] sample_ext;
   logic signed [ACC_W-1:0] acc;

   wp_row_store #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (ACC_W)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (state_ff == S_CALC),
      .wr_addr (item_slot_ff),
      .wr_data (acc),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      partial_val = $signed(rd_data);
      sample_ext  = $signed({{(ACC_W-WP_SAMPLE_W){item_sample_ff[WP_SAMPLE_W-1]}},
                             item_sample_ff});
      if (item_first_ff)                acc = sample_ext;
      else if (item_mode_ff == MODE_AVG) acc = partial_val + sample_ext;
      else                              acc = (partial_val > sample_ext) ? partial_val
                                                                          : sample_ext;
   end

   // ---------------- average divider ----------------
   wp_div_status_type       div_status;
   logic signed [ACC_W-1:0] quotient;
   logic                    div_start;

   assign div_start = (state_ff == S_CALC) && item_emit_ff && (item_mode_ff == MODE_AVG);

   wp_divider #(
      .ACC_W  (ACC_W),
      .AREA_W (AREA_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc),
      .divisor  (area),
      .status   (div_status),
      .quotient (quotient)
   );

   // ---------------- sequencer and output register ----------------
   logic [WP_SAMPLE_W-1:0] result_ff;
   logic                   rsp_valid_ff;
   logic [WP_SAMPLE_W-1:0] rsp_data_ff;
   logic                   rsp_last_ff;
   logic                   rsp_user_ff;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drained unless a new result is loaded on the same edge
         if (rsp_tready && !((state_ff == S_EMIT) && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               if (!item_emit_ff) begin
                  state_ff <= S_IDLE;
               end else if (item_mode_ff == MODE_AVG) begin
                  state_ff <= S_DIV;
               end else begin
                  // partial max window also covers the zeros beyond the edge
                  result_ff <= (item_partial_ff && acc[ACC_W-1]) ? '0
                                                                 : acc[WP_SAMPLE_W-1:0];
                  state_ff  <= S_EMIT;
               end
            end
            S_DIV: begin
               if (div_status.done) begin
                  result_ff <= quotient[WP_SAMPLE_W-1:0];
                  state_ff  <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= result_ff;
                  rsp_last_ff  <= item_row_end_ff;
                  rsp_user_ff  <= item_frame_end_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // divider is only kicked when idle
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // divider completion is only expected while waiting for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIV))
      else $error("divider done outside of divide step");

   // window offsets stay inside the window
   a_col_in_win: assert property (@(posedge clock) disable iff (reset)
      32'(col_in_win_ff) < 32'(wc_eff))
      else $error("column offset past window width");

   a_row_in_win: assert property (@(posedge clock) disable iff (reset)
      32'(row_in_win_ff) < 32'(wr_eff))
      else $error("row offset past window height");

   // frame end always closes a row
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("frame end without row end");
`endif

endmodule

`default_nettype wire
